// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the block average mapper RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked property, switched off while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same-cycle implication built on the clocked form
`define ASSERT_IMP(lbl, ante, cons, msg) \
    `ASSERT_CLK(lbl, (ante) |-> (cons), msg)
`endif

// ===== hw/rtl/bam_pkg.sv =====
// Types, constants and tables shared by the block average mapper
`default_nettype none
package bam_pkg;

    localparam int unsigned MAX_BLOCK   = 16;
    localparam int unsigned MAX_HEIGHT  = 4096;
    localparam int unsigned PIX_W       = 8;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned IDX_W       = 12;
    localparam int unsigned BS_W        = 5;
    localparam int unsigned CIB_W       = 4;
    localparam int unsigned DIM_W       = 13;
    localparam int unsigned ROW_W       = 12;
    localparam int unsigned SUM_W       = 16;
    localparam int unsigned ACC_W       = 17;
    localparam int unsigned RECIP_W     = 28;
    localparam int unsigned RECIP_SHIFT = 27;
    localparam int unsigned PROD_W      = ACC_W + RECIP_W;
    localparam int unsigned AVG_W       = PROD_W - RECIP_SHIFT;
    localparam int unsigned RAMP_W      = 4;
    localparam int unsigned CFG_IDX_W   = 2;

    localparam logic [RAMP_W-1:0] RAMP_LAST  = 4'd11;
    localparam int unsigned       FULL_SCALE = 255;
    localparam int unsigned       RAMP_STEPS = 11;
    // floor(x/255) = ((x+1)*257) >> 16 for the small products seen here
    localparam int unsigned       DIV255_MUL = 257;
    localparam int unsigned       DIV255_SH  = 16;

    localparam logic [BS_W-1:0]  BLOCK_SIZE_RST   = 5'd8;
    localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_SIZE   = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } cfg_reg_t;

    // Position of the current pixel as seen by the accumulator
    typedef struct packed {
        logic             in_store;
        logic             first;
        logic             last;
        logic             row_end;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
    } bam_pos_t;

    // Block identity carried alongside the sum
    typedef struct packed {
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
        logic             row_end;
    } bam_meta_t;

    // ceil(2^27 / (b*b)): exact floor division of any 17-bit sum
    function automatic logic [RECIP_W-1:0] recip(input logic [BS_W-1:0] b);
        logic [RECIP_W-1:0] r;
        case (b)
            5'd2:    r = 28'd33554432;
            5'd3:    r = 28'd14913081;
            5'd4:    r = 28'd8388608;
            5'd5:    r = 28'd5368710;
            5'd6:    r = 28'd3728271;
            5'd7:    r = 28'd2739138;
            5'd8:    r = 28'd2097152;
            5'd9:    r = 28'd1657009;
            5'd10:   r = 28'd1342178;
            5'd11:   r = 28'd1109238;
            5'd12:   r = 28'd932068;
            5'd13:   r = 28'd794188;
            5'd14:   r = 28'd684785;
            5'd15:   r = 28'd596524;
            5'd16:   r = 28'd524288;
            default: r = 28'd134217728;
        endcase
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] ramp_char(input logic [RAMP_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        case (idx)
            4'd0:    c = 8'h40; // @
            4'd1:    c = 8'h23; // #
            4'd2:    c = 8'h53; // S
            4'd3:    c = 8'h25; // %
            4'd4:    c = 8'h3F; // ?
            4'd5:    c = 8'h4F; // O
            4'd6:    c = 8'h2B; // +
            4'd7:    c = 8'h3B; // ;
            4'd8:    c = 8'h3A; // :
            4'd9:    c = 8'h2C; // ,
            4'd10:   c = 8'h2E; // .
            default: c = 8'h20; // space
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/block_average_ascii_mapper_top.sv =====
// Block average ASCII mapper: position tracking, column sum store, mapper
// Throughput: one pixel per cycle; the input stalls only while a finished block
//   waits on a mapper whose three stages are all held by m_tready low.
// A block's last pixel reaches m_tvalid via the b, s, p and o registers.
// Reset: rst_n clears counters and pipeline valids and restores the default
//   configuration; the sum store needs no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module block_average_ascii_mapper_top #(
    parameter int unsigned MAX_WIDTH      = 4096,
    parameter int unsigned MAX_BLOCK_COLS = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    input  wire logic [7:0]                    s_tdata,    // [7:0] pixel
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    output      logic [31:0]                   m_tdata,    // [7:0] char_code,
                                                           // [19:8] block_col,
                                                           // [31:20] block_row
    output      logic                          m_tlast,    // row_end
    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic [bam_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bam_pkg::DIM_W-1:0]     cfg_data
);

    localparam int unsigned AW    = $clog2(MAX_BLOCK_COLS);
    localparam int unsigned SUM_W = bam_pkg::SUM_W;
    localparam int unsigned ACC_W = bam_pkg::ACC_W;

    bam_pkg::bam_pos_t             pos;
    logic [bam_pkg::BS_W-1:0]      blk;
    logic                          accept;
    logic [SUM_W-1:0]              ram_rdata;
    logic                          ram_we;

    logic                          b_valid_reg, b_valid_next;
    logic                          b_first_reg;
    logic                          b_last_reg;
    logic [bam_pkg::PIX_W-1:0]     b_pix_reg;
    logic [AW-1:0]                 b_addr_reg;
    bam_pkg::bam_meta_t            b_meta_reg;

    logic                          lw_valid_reg, lw_valid_next;
    logic [AW-1:0]                 lw_addr_reg;
    logic [SUM_W-1:0]              lw_data_reg;

    logic [SUM_W-1:0]              base;
    logic [ACC_W-1:0]              sum;
    logic                          map_ready;
    logic                          map_push;
    logic [bam_pkg::CHAR_W-1:0]    out_char;
    bam_pkg::bam_meta_t            out_meta;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    bam_pos #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_BLOCK_COLS (MAX_BLOCK_COLS)
    ) u_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .pos       (pos),
        .blk       (blk)
    );

    bam_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_BLOCK_COLS)
    ) u_sums (
        .clk   (clk),
        .we    (ram_we),
        .waddr (b_addr_reg),
        .wdata (sum[SUM_W-1:0]),
        .re    (accept),
        .raddr (AW'(pos.col)),
        .rdata (ram_rdata)
    );

    // Bypass the store when the last write went to the entry just read
    assign base = (lw_valid_reg && lw_addr_reg == b_addr_reg) ? lw_data_reg : ram_rdata;
    assign sum  = b_first_reg ? ACC_W'(b_pix_reg)
                              : ACC_W'(base) + ACC_W'(b_pix_reg);

    assign map_push = b_valid_reg && b_last_reg;
    // Hold the accumulate stage only while a finished block waits for the mapper
    assign s_tready = !b_valid_reg || !b_last_reg || map_ready;
    assign ram_we   = b_valid_reg && s_tready;

    always_comb
    begin
        b_valid_next  = s_tready ? (s_tvalid && pos.in_store) : b_valid_reg;
        lw_valid_next = lw_valid_reg || ram_we;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg  <= 1'b0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg  <= b_valid_next;
            lw_valid_reg <= lw_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_first_reg         <= pos.first;
            b_last_reg          <= pos.last;
            b_pix_reg           <= s_tdata;
            b_addr_reg          <= AW'(pos.col);
            b_meta_reg.col      <= pos.col;
            b_meta_reg.row      <= pos.row;
            b_meta_reg.row_end  <= pos.row_end;
        end
        if (ram_we)
        begin
            lw_addr_reg <= b_addr_reg;
            lw_data_reg <= sum[SUM_W-1:0];
        end
    end

    bam_map u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (map_push),
        .in_ready  (map_ready),
        .in_sum    (sum),
        .in_meta   (b_meta_reg),
        .blk       (blk),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char),
        .out_meta  (out_meta)
    );

    assign m_tdata = {out_meta.row, out_meta.col, out_char};
    assign m_tlast = out_meta.row_end;

    `ASSERT_IMP(a_stall_only_on_block_end, !s_tready, map_push, "stall without a waiting block")
    `ASSERT_CLK(a_store_pixel_enters, (accept && pos.in_store) |=> b_valid_reg, "store pixel lost")
    `ASSERT_CLK(a_rdata_held, (!s_tready && !b_first_reg) |=> $stable(ram_rdata), "rdata moved")

endmodule
`default_nettype wire

// ===== hw/rtl/bam_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module bam_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/bam_pos.sv =====
// Configuration registers and raster position counters
`default_nettype none
module bam_pos #(
    parameter int unsigned MAX_WIDTH      = 4096,
    parameter int unsigned MAX_BLOCK_COLS = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [bam_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bam_pkg::DIM_W-1:0]      cfg_data,
    input  wire logic                           advance,
    output      bam_pkg::bam_pos_t              pos,
    output      logic [bam_pkg::BS_W-1:0]       blk
);

    localparam int unsigned W_W   = $clog2(MAX_WIDTH + 1);
    localparam int unsigned COL_W = $clog2(MAX_WIDTH);
    localparam int unsigned EW    = W_W + 1;
    localparam int unsigned HW    = bam_pkg::DIM_W + 1;
    localparam int unsigned BS_W  = bam_pkg::BS_W;
    localparam int unsigned CIB_W = bam_pkg::CIB_W;
    localparam int unsigned IDX_W = bam_pkg::IDX_W;
    localparam int unsigned DIM_W = bam_pkg::DIM_W;
    localparam int unsigned ROW_W = bam_pkg::ROW_W;

    logic [BS_W-1:0]  bs_reg,   bs_next;
    logic [DIM_W-1:0] iw_reg,   iw_next;
    logic [DIM_W-1:0] ih_reg,   ih_next;
    logic [COL_W-1:0] pcol_reg, pcol_next;
    logic [ROW_W-1:0] prow_reg, prow_next;
    logic [CIB_W-1:0] cib_reg,  cib_next;
    logic [CIB_W-1:0] rib_reg,  rib_next;
    logic [IDX_W-1:0] bcol_reg, bcol_next;
    logic [IDX_W-1:0] brow_reg, brow_next;

    logic [W_W-1:0]   w_clamp;
    logic [DIM_W-1:0] h_clamp;
    logic             fits_x;
    logic             fits_y;
    logic             col_wrap;
    logic             row_wrap;
    logic             cib_wrap;
    logic             rib_wrap;

    // Clamp configuration to legal ranges
    always_comb
    begin
        if (bs_reg == '0)
            blk = BS_W'(1);
        else if (32'(bs_reg) > bam_pkg::MAX_BLOCK)
            blk = BS_W'(bam_pkg::MAX_BLOCK);
        else
            blk = bs_reg;

        if (iw_reg == '0)
            w_clamp = W_W'(1);
        else if (32'(iw_reg) > MAX_WIDTH)
            w_clamp = W_W'(MAX_WIDTH);
        else
            w_clamp = W_W'(iw_reg);

        if (ih_reg == '0)
            h_clamp = DIM_W'(1);
        else if (32'(ih_reg) > bam_pkg::MAX_HEIGHT)
            h_clamp = DIM_W'(bam_pkg::MAX_HEIGHT);
        else
            h_clamp = ih_reg;
    end

    // A block counts only when its whole extent lies inside the image
    assign fits_x   = (EW'(pcol_reg) - EW'(cib_reg) + EW'(blk)) <= EW'(w_clamp);
    assign fits_y   = (HW'(prow_reg) - HW'(rib_reg) + HW'(blk)) <= HW'(h_clamp);
    assign col_wrap = (EW'(pcol_reg) + EW'(1)) >= EW'(w_clamp);
    assign row_wrap = (HW'(prow_reg) + HW'(1)) >= HW'(h_clamp);
    assign cib_wrap = (BS_W'(cib_reg) + BS_W'(1)) >= blk;
    assign rib_wrap = (BS_W'(rib_reg) + BS_W'(1)) >= blk;

    always_comb
    begin
        pos.in_store = fits_x && fits_y && (32'(bcol_reg) < MAX_BLOCK_COLS);
        pos.first    = (cib_reg == '0) && (rib_reg == '0);
        pos.last     = cib_wrap && rib_wrap;
        pos.row_end  = (EW'(pcol_reg) - EW'(cib_reg) + EW'({blk, 1'b0}))
                       > EW'(w_clamp);
        pos.col      = bcol_reg;
        pos.row      = brow_reg;
    end

    always_comb
    begin
        bs_next   = bs_reg;
        iw_next   = iw_reg;
        ih_next   = ih_reg;
        pcol_next = pcol_reg;
        prow_next = prow_reg;
        cib_next  = cib_reg;
        rib_next  = rib_reg;
        bcol_next = bcol_reg;
        brow_next = brow_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                bam_pkg::REG_BLOCK_SIZE:   bs_next = cfg_data[BS_W-1:0];
                bam_pkg::REG_IMAGE_WIDTH:  iw_next = cfg_data;
                bam_pkg::REG_IMAGE_HEIGHT: ih_next = cfg_data;
                default:                   bs_next = bs_reg;
            endcase
            // A valid register write restarts the frame
            if (cfg_index == bam_pkg::REG_BLOCK_SIZE ||
                cfg_index == bam_pkg::REG_IMAGE_WIDTH ||
                cfg_index == bam_pkg::REG_IMAGE_HEIGHT)
            begin
                pcol_next = '0;
                prow_next = '0;
                cib_next  = '0;
                rib_next  = '0;
                bcol_next = '0;
                brow_next = '0;
            end
        end
        else if (advance)
        begin
            if (col_wrap)
            begin
                pcol_next = '0;
                cib_next  = '0;
                bcol_next = '0;
                if (row_wrap)
                begin
                    prow_next = '0;
                    rib_next  = '0;
                    brow_next = '0;
                end
                else
                begin
                    prow_next = prow_reg + ROW_W'(1);
                    if (rib_wrap)
                    begin
                        rib_next  = '0;
                        brow_next = brow_reg + IDX_W'(1);
                    end
                    else
                    begin
                        rib_next = rib_reg + CIB_W'(1);
                    end
                end
            end
            else
            begin
                pcol_next = pcol_reg + COL_W'(1);
                if (cib_wrap)
                begin
                    cib_next  = '0;
                    bcol_next = bcol_reg + IDX_W'(1);
                end
                else
                begin
                    cib_next = cib_reg + CIB_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_reg   <= bam_pkg::BLOCK_SIZE_RST;
            iw_reg   <= bam_pkg::IMAGE_WIDTH_RST;
            ih_reg   <= bam_pkg::IMAGE_HEIGHT_RST;
            pcol_reg <= '0;
            prow_reg <= '0;
            cib_reg  <= '0;
            rib_reg  <= '0;
            bcol_reg <= '0;
            brow_reg <= '0;
        end
        else
        begin
            bs_reg   <= bs_next;
            iw_reg   <= iw_next;
            ih_reg   <= ih_next;
            pcol_reg <= pcol_next;
            prow_reg <= prow_next;
            cib_reg  <= cib_next;
            rib_reg  <= rib_next;
            bcol_reg <= bcol_next;
            brow_reg <= brow_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bam_map.sv =====
// Block sum to ramp character: reciprocal multiply, scale and table lookup
`default_nettype none
`include "assert_macros.svh"
module bam_map (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output      logic                          in_ready,
    input  wire logic [bam_pkg::ACC_W-1:0]     in_sum,
    input  wire bam_pkg::bam_meta_t            in_meta,
    input  wire logic [bam_pkg::BS_W-1:0]      blk,
    output      logic                          out_valid,
    input  wire logic                          out_ready,
    output      logic [bam_pkg::CHAR_W-1:0]    out_char,
    output      bam_pkg::bam_meta_t            out_meta
);

    localparam int unsigned ACC_W  = bam_pkg::ACC_W;
    localparam int unsigned PROD_W = bam_pkg::PROD_W;
    localparam int unsigned AVG_W  = bam_pkg::AVG_W;
    localparam int unsigned X_W    = 13;
    localparam int unsigned Q_W    = 21;

    logic                          s_valid_reg, s_valid_next;
    logic                          p_valid_reg, p_valid_next;
    logic                          o_valid_reg, o_valid_next;
    logic [bam_pkg::RECIP_W-1:0]   recip_reg;
    logic [ACC_W-1:0]              s_sum_reg;
    bam_pkg::bam_meta_t            s_meta_reg;
    logic [PROD_W-1:0]             p_prod_reg;
    bam_pkg::bam_meta_t            p_meta_reg;
    logic [bam_pkg::CHAR_W-1:0]    o_char_reg;
    bam_pkg::bam_meta_t            o_meta_reg;

    logic                          o_adv;
    logic                          p_adv;
    logic                          s_adv;
    logic [AVG_W-1:0]              avg;
    logic [X_W-1:0]                x_plus;
    logic [Q_W-1:0]                q_full;
    logic [bam_pkg::RAMP_W-1:0]    idx;

    assign o_adv    = !o_valid_reg || out_ready;
    assign p_adv    = !p_valid_reg || o_adv;
    assign s_adv    = !s_valid_reg || p_adv;
    assign in_ready = s_adv;

    // avg = floor(sum / (b*b)), then idx = avg*11/255 capped at the last entry
    assign avg    = p_prod_reg[PROD_W-1:bam_pkg::RECIP_SHIFT];
    assign x_plus = X_W'(avg[7:0]) * X_W'(bam_pkg::RAMP_STEPS) + X_W'(1);
    assign q_full = Q_W'(x_plus) * Q_W'(bam_pkg::DIV255_MUL);

    always_comb
    begin
        if (avg >= AVG_W'(bam_pkg::FULL_SCALE))
            idx = bam_pkg::RAMP_LAST;
        else
            idx = q_full[bam_pkg::DIV255_SH +: bam_pkg::RAMP_W];
    end

    always_comb
    begin
        s_valid_next = s_adv ? in_valid    : s_valid_reg;
        p_valid_next = p_adv ? s_valid_reg : p_valid_reg;
        o_valid_next = o_adv ? p_valid_reg : o_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg <= s_valid_next;
            p_valid_reg <= p_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        recip_reg <= bam_pkg::recip(blk);
        if (s_adv && in_valid)
        begin
            s_sum_reg  <= in_sum;
            s_meta_reg <= in_meta;
        end
        if (p_adv && s_valid_reg)
        begin
            p_prod_reg <= PROD_W'(s_sum_reg) * PROD_W'(recip_reg);
            p_meta_reg <= s_meta_reg;
        end
        if (o_adv && p_valid_reg)
        begin
            o_char_reg <= bam_pkg::ramp_char(idx);
            o_meta_reg <= p_meta_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_char  = o_char_reg;
    assign out_meta  = o_meta_reg;

    `ASSERT_CLK(a_full_scale_char, (p_valid_reg && o_adv && avg >= AVG_W'(bam_pkg::FULL_SCALE)) |=> (o_char_reg == bam_pkg::ramp_char(bam_pkg::RAMP_LAST)), "full scale block did not map to the last ramp entry")
    `ASSERT_IMP(a_stall_needs_full_chain, !in_ready, (s_valid_reg && p_valid_reg && o_valid_reg), "mapper refused a request with a free stage")

endmodule
`default_nettype wire
